### hdl/lzwc_pkg.sv
// Shared types and constants for the LZW byte compressor.
`timescale 1ns / 1ps

package lzwc_pkg;

    // Codes below this value stand for single bytes
    localparam int FIRST_CODE    = 256;
    localparam int BYTE_BITS     = 8;
    localparam int OUT_CODE_BITS = 12;

    // Control bits that travel with a search token along the cell row
    typedef struct packed {
        logic valid;
        logic last;
        logic hit;
    } chain_ctl_t;

    // One result item as held in the output queue
    typedef struct packed {
        logic [OUT_CODE_BITS-1:0] code;
        logic                     last_code;
    } result_t;

endpackage

### hdl/lzwc_cell.sv
// One search cell: a bank of dictionary entries and a compare stage.
`timescale 1ns / 1ps

module lzwc_cell #(
    parameter int CODE_BITS  = 12,
    parameter int CELL_BITS  = 5,
    parameter int CELL_INDEX = 0,
    parameter int ADDR_BITS  = 7,
    parameter int BANK_DEPTH = 120,
    parameter int USED_BITS  = 12
) (
    input  logic                                  clk,
    input  logic                                  rst_n,
    // token from the left neighbor
    input  lzwc_pkg::chain_ctl_t                  in_ctl,
    input  logic [ADDR_BITS-1:0]                  in_addr,
    input  logic [CODE_BITS+lzwc_pkg::BYTE_BITS-1:0] in_key,
    input  logic [CODE_BITS-1:0]                  in_code,
    // token to the right neighbor
    output lzwc_pkg::chain_ctl_t                  out_ctl,
    output logic [ADDR_BITS-1:0]                  out_addr,
    output logic [CODE_BITS+lzwc_pkg::BYTE_BITS-1:0] out_key,
    output logic [CODE_BITS-1:0]                  out_code,
    // number of dictionary entries in use
    input  logic [USED_BITS-1:0]                  used,
    // entry write
    input  logic                                  wr_en,
    input  logic [ADDR_BITS-1:0]                  wr_addr,
    input  logic [CODE_BITS+lzwc_pkg::BYTE_BITS-1:0] wr_data
);

    localparam int KEY_BITS = CODE_BITS + lzwc_pkg::BYTE_BITS;
    localparam int IDX_BITS = ADDR_BITS + CELL_BITS;
    localparam int CMP_BITS = (IDX_BITS > USED_BITS) ? IDX_BITS : USED_BITS;

    logic [KEY_BITS-1:0]  mem [BANK_DEPTH];
    logic [KEY_BITS-1:0]  rdata_reg;
    lzwc_pkg::chain_ctl_t ctl_reg;
    logic [ADDR_BITS-1:0] addr_reg;
    logic [KEY_BITS-1:0]  key_reg;
    logic [CODE_BITS-1:0] code_reg;

    logic [IDX_BITS-1:0]  entry_idx;
    logic [CODE_BITS-1:0] entry_code;
    logic                 match;

    // bank: entry i of the dictionary lives in cell i mod NUM_CELLS
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        rdata_reg <= mem[in_addr];
    end

    // token stage
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ctl_reg <= '0;
        end
        else
        begin
            ctl_reg <= in_ctl;
        end
    end

    always_ff @(posedge clk)
    begin
        addr_reg <= in_addr;
        key_reg  <= in_key;
        code_reg <= in_code;
    end

    // compare against the entry read for this token; unwritten slots sit at or above used
    assign entry_idx  = {addr_reg, CELL_BITS'(CELL_INDEX)};
    assign entry_code = CODE_BITS'(lzwc_pkg::FIRST_CODE) + CODE_BITS'(entry_idx);
    assign match      = ctl_reg.valid
                        && (CMP_BITS'(entry_idx) < CMP_BITS'(used))
                        && (rdata_reg == key_reg);

    assign out_ctl.valid = ctl_reg.valid;
    assign out_ctl.last  = ctl_reg.last;
    assign out_ctl.hit   = ctl_reg.hit | match;
    assign out_code      = match ? entry_code : code_reg;
    assign out_addr      = addr_reg;
    assign out_key       = key_reg;

endmodule

### hdl/lzwc_out_queue.sv
// Two-item result queue between the compressor core and the output channel.
`timescale 1ns / 1ps

module lzwc_out_queue (
    input  logic               clk,
    input  logic               rst_n,
    // push side: up to two items in one cycle, only when room is free
    input  logic [1:0]         push_num,
    input  lzwc_pkg::result_t  push_first,
    input  lzwc_pkg::result_t  push_second,
    output logic [1:0]         free_slots,
    // output channel
    output logic               out_valid,
    input  logic               out_ready,
    output lzwc_pkg::result_t  out_item
);

    logic [1:0]        count_reg, count_next;
    lzwc_pkg::result_t slot0_reg, slot0_next;
    lzwc_pkg::result_t slot1_reg, slot1_next;

    logic       pop;
    logic [1:0] kept;

    assign out_valid  = (count_reg != 2'd0);
    assign out_item   = slot0_reg;
    assign free_slots = 2'd2 - count_reg;
    assign pop        = out_valid & out_ready;

    // shift out the head, then append new items behind what is kept
    always_comb
    begin
        kept       = count_reg - {1'b0, pop};
        slot0_next = pop ? slot1_reg : slot0_reg;
        slot1_next = slot1_reg;
        if (push_num != 2'd0)
        begin
            if (kept == 2'd0)
            begin
                slot0_next = push_first;
                slot1_next = push_second;
            end
            else
            begin
                slot1_next = push_first;
            end
        end
        count_next = kept + push_num;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= 2'd0;
        end
        else
        begin
            count_reg <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        slot0_reg <= slot0_next;
        slot1_reg <= slot1_next;
    end

endmodule

### hdl/lzw_byte_compressor.sv
// Top level of the LZW byte compressor: control, cell row and result queue.
`timescale 1ns / 1ps

// LZW compressor taking one byte per item and giving 12-bit code items.
// The dictionary is spread over a row of NUM_CELLS = 2^CELL_BITS cells, each
// holding every NUM_CELLS-th entry in a small bank. A lookup sends
// S = ceil(entries_in_use / NUM_CELLS) tokens down the row, one per cycle;
// each cell checks its bank entry and hands the token and any hit to its
// neighbor. An item that starts a stream, or meets an empty dictionary, skips
// the lookup and goes straight to emit; any other item waits for the sweep
// over the banks and the trip through the row. Emit also waits for room in
// the result queue. Results go to a two-item queue, so the next byte is
// taken while results still wait. Entries are tracked by a fill count, so
// there is no clearing pass after reset or at the end of a stream.
module lzw_byte_compressor #(
    parameter int CODE_BITS    = 12,
    parameter int DICT_ENTRIES = 4096,
    parameter int CELL_BITS    = 5
) (
    input  logic                                 clk,
    input  logic                                 rst_n,
    // input channel
    input  logic                                 in_valid,
    output logic                                 in_ready,
    input  logic [lzwc_pkg::BYTE_BITS-1:0]       data_byte,
    input  logic                                 end_of_stream,
    // output channel
    output logic                                 out_valid,
    input  logic                                 out_ready,
    output logic [lzwc_pkg::OUT_CODE_BITS-1:0]   code_word,
    output logic                                 final_code
);

    localparam int CODE_SPACE  = 1 << CODE_BITS;
    localparam int CODE_LIMIT  = (DICT_ENTRIES < CODE_SPACE) ? DICT_ENTRIES : CODE_SPACE;
    localparam int STORE_DEPTH = CODE_LIMIT - lzwc_pkg::FIRST_CODE;
    localparam int NUM_CELLS   = 1 << CELL_BITS;
    localparam int BANK_DEPTH  = (STORE_DEPTH + NUM_CELLS - 1) / NUM_CELLS;
    localparam int ADDR_BITS   = (BANK_DEPTH > 1) ? $clog2(BANK_DEPTH) : 1;
    localparam int FREE_BITS   = $clog2(CODE_LIMIT + 1);
    localparam int USED_BITS   = $clog2(STORE_DEPTH + 1);
    localparam int SWEEP_BITS  = $clog2(BANK_DEPTH + 1);
    localparam int KEY_BITS    = CODE_BITS + lzwc_pkg::BYTE_BITS;

    localparam logic [1:0] ST_IDLE  = 2'd0;
    localparam logic [1:0] ST_SWEEP = 2'd1;
    localparam logic [1:0] ST_DRAIN = 2'd2;
    localparam logic [1:0] ST_EMIT  = 2'd3;

    // control state
    logic [1:0]            state_reg, state_next;
    logic [CODE_BITS-1:0]  prefix_reg, prefix_next;
    logic                  prefix_valid_reg, prefix_valid_next;
    logic [FREE_BITS-1:0]  next_free_reg, next_free_next;
    logic [ADDR_BITS-1:0]  sweep_addr_reg, sweep_addr_next;
    logic [SWEEP_BITS-1:0] sweep_len_reg, sweep_len_next;
    logic                  hit_acc_reg, hit_acc_next;
    // item payload
    logic [lzwc_pkg::BYTE_BITS-1:0] byte_reg, byte_next;
    logic                  last_reg, last_next;
    logic [CODE_BITS-1:0]  hit_code_reg, hit_code_next;

    // cell row links
    lzwc_pkg::chain_ctl_t  link_ctl  [NUM_CELLS+1];
    logic [ADDR_BITS-1:0]  link_addr [NUM_CELLS+1];
    logic [KEY_BITS-1:0]   link_key  [NUM_CELLS+1];
    logic [CODE_BITS-1:0]  link_code [NUM_CELLS+1];

    logic [USED_BITS-1:0]  used_count;
    logic [USED_BITS:0]    used_round;
    logic                  sweep_last;

    logic                  wr_en;
    logic [USED_BITS-1:0]  wr_slot;
    logic [ADDR_BITS-1:0]  wr_addr;
    logic [CELL_BITS-1:0]  wr_cell;
    logic [KEY_BITS-1:0]   wr_data;

    logic                  miss;
    logic [CODE_BITS-1:0]  new_prefix;
    logic [1:0]            need_num;
    logic [1:0]            push_num;
    logic [1:0]            free_slots;
    logic                  emit_go;
    lzwc_pkg::result_t     push_first, push_second, out_item;

    // fill count and sweep length for the current dictionary
    assign used_count = USED_BITS'(next_free_reg - FREE_BITS'(lzwc_pkg::FIRST_CODE));
    assign used_round = {1'b0, used_count} + (USED_BITS+1)'(NUM_CELLS - 1);
    assign sweep_last = (SWEEP_BITS'(sweep_addr_reg) + SWEEP_BITS'(1)) == sweep_len_reg;

    assign in_ready = (state_reg == ST_IDLE);

    // token into the first cell
    assign link_ctl[0].valid = (state_reg == ST_SWEEP);
    assign link_ctl[0].last  = sweep_last;
    assign link_ctl[0].hit   = 1'b0;
    assign link_addr[0]      = sweep_addr_reg;
    assign link_key[0]       = {prefix_reg, byte_reg};
    assign link_code[0]      = '0;

    // outcome of the lookup
    assign miss       = prefix_valid_reg && !hit_acc_reg;
    assign new_prefix = (prefix_valid_reg && hit_acc_reg) ? hit_code_reg
                                                          : CODE_BITS'(byte_reg);
    assign need_num   = {1'b0, miss} + {1'b0, last_reg};
    assign emit_go    = (state_reg == ST_EMIT) && (free_slots >= need_num);
    assign push_num   = emit_go ? need_num : 2'd0;

    assign push_first.code       = miss ? lzwc_pkg::OUT_CODE_BITS'(prefix_reg)
                                        : lzwc_pkg::OUT_CODE_BITS'(new_prefix);
    assign push_first.last_code  = !miss;
    assign push_second.code      = lzwc_pkg::OUT_CODE_BITS'(new_prefix);
    assign push_second.last_code = 1'b1;

    // new entry on a miss while the dictionary has room
    assign wr_en   = emit_go && miss && (next_free_reg < FREE_BITS'(CODE_LIMIT));
    assign wr_slot = used_count;
    assign wr_cell = wr_slot[CELL_BITS-1:0];
    assign wr_addr = ADDR_BITS'(wr_slot >> CELL_BITS);
    assign wr_data = {prefix_reg, byte_reg};

    // sequencer
    always_comb
    begin
        state_next        = state_reg;
        prefix_next       = prefix_reg;
        prefix_valid_next = prefix_valid_reg;
        next_free_next    = next_free_reg;
        sweep_addr_next   = sweep_addr_reg;
        sweep_len_next    = sweep_len_reg;
        hit_acc_next      = hit_acc_reg;
        byte_next         = byte_reg;
        last_next         = last_reg;
        hit_code_next     = hit_code_reg;

        // collect a hit from the end of the row
        if (link_ctl[NUM_CELLS].valid && link_ctl[NUM_CELLS].hit)
        begin
            hit_acc_next  = 1'b1;
            hit_code_next = link_code[NUM_CELLS];
        end

        case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    byte_next       = data_byte;
                    last_next       = end_of_stream;
                    hit_acc_next    = 1'b0;
                    sweep_addr_next = '0;
                    sweep_len_next  = SWEEP_BITS'(used_round >> CELL_BITS);
                    if (prefix_valid_reg && (used_count != '0))
                    begin
                        state_next = ST_SWEEP;
                    end
                    else
                    begin
                        state_next = ST_EMIT;
                    end
                end
            end
            ST_SWEEP:
            begin
                sweep_addr_next = sweep_addr_reg + ADDR_BITS'(1);
                if (sweep_last)
                begin
                    state_next = ST_DRAIN;
                end
            end
            ST_DRAIN:
            begin
                if (link_ctl[NUM_CELLS].valid && link_ctl[NUM_CELLS].last)
                begin
                    state_next = ST_EMIT;
                end
            end
            ST_EMIT:
            begin
                if (emit_go)
                begin
                    state_next        = ST_IDLE;
                    prefix_next       = new_prefix;
                    prefix_valid_next = 1'b1;
                    if (wr_en)
                    begin
                        next_free_next = next_free_reg + FREE_BITS'(1);
                    end
                    // end of stream: start over with an empty dictionary
                    if (last_reg)
                    begin
                        prefix_next       = '0;
                        prefix_valid_next = 1'b0;
                        next_free_next    = FREE_BITS'(lzwc_pkg::FIRST_CODE);
                    end
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= ST_IDLE;
            prefix_reg       <= '0;
            prefix_valid_reg <= 1'b0;
            next_free_reg    <= FREE_BITS'(lzwc_pkg::FIRST_CODE);
            sweep_addr_reg   <= '0;
            sweep_len_reg    <= '0;
            hit_acc_reg      <= 1'b0;
        end
        else
        begin
            state_reg        <= state_next;
            prefix_reg       <= prefix_next;
            prefix_valid_reg <= prefix_valid_next;
            next_free_reg    <= next_free_next;
            sweep_addr_reg   <= sweep_addr_next;
            sweep_len_reg    <= sweep_len_next;
            hit_acc_reg      <= hit_acc_next;
        end
    end

    always_ff @(posedge clk)
    begin
        byte_reg     <= byte_next;
        last_reg     <= last_next;
        hit_code_reg <= hit_code_next;
    end

    // row of search cells
    for (genvar i = 0; i < NUM_CELLS; i++)
    begin : g_cell
        lzwc_cell #(
            .CODE_BITS  (CODE_BITS),
            .CELL_BITS  (CELL_BITS),
            .CELL_INDEX (i),
            .ADDR_BITS  (ADDR_BITS),
            .BANK_DEPTH (BANK_DEPTH),
            .USED_BITS  (USED_BITS)
        ) u_cell (
            .clk      (clk),
            .rst_n    (rst_n),
            .in_ctl   (link_ctl[i]),
            .in_addr  (link_addr[i]),
            .in_key   (link_key[i]),
            .in_code  (link_code[i]),
            .out_ctl  (link_ctl[i+1]),
            .out_addr (link_addr[i+1]),
            .out_key  (link_key[i+1]),
            .out_code (link_code[i+1]),
            .used     (used_count),
            .wr_en    (wr_en && (wr_cell == CELL_BITS'(i))),
            .wr_addr  (wr_addr),
            .wr_data  (wr_data)
        );
    end

    // result queue
    lzwc_out_queue u_out_queue (
        .clk         (clk),
        .rst_n       (rst_n),
        .push_num    (push_num),
        .push_first  (push_first),
        .push_second (push_second),
        .free_slots  (free_slots),
        .out_valid   (out_valid),
        .out_ready   (out_ready),
        .out_item    (out_item)
    );

    assign code_word  = out_item.code;
    assign final_code = out_item.last_code;

endmodule

### tb/tb.sv
// Self-checking testbench for the LZW byte compressor: directed table and random streams.
`timescale 1ns / 1ps

module tb;

    localparam int TB_CODE_BITS    = 12;
    localparam int TB_DICT_ENTRIES = 4096;
    // Highest code count the dictionary may reach
    localparam int CODE_LIMIT = (TB_DICT_ENTRIES < (1 << TB_CODE_BITS)) ?
                                TB_DICT_ENTRIES : (1 << TB_CODE_BITS);
    localparam int HOLD_CYCLES    = 600;
    localparam int TAIL_CYCLES    = 400;
    localparam int CYCLE_LIMIT    = 4000000;
    localparam int LONG_STREAM    = 200;

    // Content shapes of a random stream
    typedef enum int {
        MIX_RANDOM,
        MIX_ALPHABET,
        MIX_MOTIF,
        MIX_NOISE
    } stream_mix_t;

    // One row of the directed table
    typedef struct packed {
        logic [7:0]        b;
        logic              eos;
        bit                typed;
        int                n;
        lzwc_pkg::result_t r0;
        lzwc_pkg::result_t r1;
    } row_t;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        in_valid = 1'b0;
    logic        in_ready;
    logic [7:0]  data_byte = 8'h00;
    logic        end_of_stream = 1'b0;
    logic        out_valid;
    logic        out_ready = 1'b0;
    logic [11:0] code_word;
    logic        final_code;

    // Compressor state as predicted
    logic [11:0] pfx_code;
    logic        pfx_held;
    logic [12:0] free_code;
    logic [11:0] pair_codes [int];

    lzwc_pkg::result_t pending_codes [$];
    row_t              rows [$];

    int          send_idle_pct = 0;
    int          recv_idle_pct = 0;
    bit          stall_req = 1'b0;
    int          hold_left = 0;
    int          errors = 0;
    int          items_sent = 0;
    int          codes_seen = 0;
    int          streams_sent = 0;
    int          longest_stream = 0;
    int          full_misses = 0;
    int          cycle_count = 0;

    lzw_byte_compressor #(
        .CODE_BITS    (TB_CODE_BITS),
        .DICT_ENTRIES (TB_DICT_ENTRIES)
    ) dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .in_valid      (in_valid),
        .in_ready      (in_ready),
        .data_byte     (data_byte),
        .end_of_stream (end_of_stream),
        .out_valid     (out_valid),
        .out_ready     (out_ready),
        .code_word     (code_word),
        .final_code    (final_code)
    );

    // 8 ns clock
    always
    begin
        #4 clk = 1'b1;
        #4 clk = 1'b0;
    end

    task automatic report_mismatch(input string msg);
        $display("ERROR @%0t: %s", $realtime, msg);
        errors++;
    endtask

    // Clear prefix and dictionary, as at reset and after a last byte
    function automatic void clear_dictionary();
        pfx_code  = '0;
        pfx_held  = 1'b0;
        free_code = 13'(lzwc_pkg::FIRST_CODE);
        pair_codes.delete();
    endfunction

    // Advance the predicted state by one byte; returns the number of codes it emits
    function automatic int compress_byte(input logic [7:0] b, input logic eos,
                                         output lzwc_pkg::result_t r0,
                                         output lzwc_pkg::result_t r1);
        int n;
        int key;
        n   = 0;
        r0  = '0;
        r1  = '0;
        key = (int'(pfx_code) << 8) | int'(b);
        if (!pfx_held)
        begin
            pfx_code = {4'h0, b};
            pfx_held = 1'b1;
        end
        else if (pair_codes.exists(key))
        begin
            pfx_code = pair_codes[key];
        end
        else
        begin
            // miss: emit the prefix, learn the pair if room is left
            r0 = {pfx_code, 1'b0};
            n  = 1;
            if (int'(free_code) < CODE_LIMIT)
            begin
                pair_codes[key] = free_code[11:0];
                free_code++;
            end
            else
            begin
                full_misses++;
            end
            pfx_code = {4'h0, b};
        end
        if (eos)
        begin
            if (n == 0)
                r0 = {pfx_code, 1'b1};
            else
                r1 = {pfx_code, 1'b1};
            n++;
            clear_dictionary();
        end
        return n;
    endfunction

    // Offer one byte item, wait for it to be taken, then queue its codes
    task automatic send_byte(input logic [7:0] b, input logic eos, input bit typed,
                             input int tn, input lzwc_pkg::result_t t0,
                             input lzwc_pkg::result_t t1);
        int                n;
        lzwc_pkg::result_t p0;
        lzwc_pkg::result_t p1;
        while ($urandom_range(99) < send_idle_pct)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid      <= 1'b1;
        data_byte     <= b;
        end_of_stream <= eos;
        do
            @(posedge clk);
        while (!in_ready);
        n = compress_byte(b, eos, p0, p1);
        if (typed)
        begin
            n  = tn;
            p0 = t0;
            p1 = t1;
        end
        if (n > 0)
            pending_codes.push_back(p0);
        if (n > 1)
            pending_codes.push_back(p1);
        items_sent++;
    endtask

    // One random stream, mostly short, with content in some mixes shaped to produce matches
    task automatic random_stream();
        stream_mix_t mix;
        int          len;
        int          nsym;
        int          i;
        logic [7:0]  syms [8];
        logic [7:0]  b;
        mix  = stream_mix_t'($urandom_range(3));
        len  = ($urandom_range(9) == 0) ? $urandom_range(60, 300) : $urandom_range(1, 30);
        nsym = (mix == MIX_ALPHABET) ? $urandom_range(2, 4) : $urandom_range(1, 6);
        if (mix == MIX_NOISE)
            len = $urandom_range(1, 2);
        for (i = 0; i < 8; i++)
            syms[i] = 8'($urandom);
        for (i = 0; i < len; i++)
        begin
            case (mix)
                MIX_ALPHABET: b = syms[$urandom_range(nsym - 1)];
                MIX_MOTIF:    b = ($urandom_range(9) == 0) ? 8'($urandom) : syms[i % nsym];
                default:      b = 8'($urandom);
            endcase
            send_byte(b, i == len - 1, 1'b0, 0, '0, '0);
        end
        streams_sent++;
        if (len > longest_stream)
            longest_stream = len;
    endtask

    function automatic void add_row(input logic [7:0] b, input logic eos, input bit typed,
                                    input int n, input lzwc_pkg::result_t r0,
                                    input lzwc_pkg::result_t r1);
        row_t r;
        r.b     = b;
        r.eos   = eos;
        r.typed = typed;
        r.n     = n;
        r.r0    = r0;
        r.r1    = r1;
        rows.push_back(r);
    endfunction

    // Result side: check each taken item, then pick ready for the next cycle
    always @(posedge clk)
    begin : result_check
        lzwc_pkg::result_t want;
        if (rst_n && out_valid && out_ready)
        begin
            if (pending_codes.size() == 0)
            begin
                report_mismatch($sformatf("code %0d final %0b with no item waiting",
                                          code_word, final_code));
            end
            else
            begin
                want = pending_codes.pop_front();
                if (code_word !== want.code)
                    report_mismatch($sformatf("code_word %0d, expected %0d",
                                              code_word, want.code));
                if (final_code !== want.last_code)
                    report_mismatch($sformatf("final_code %0b, expected %0b (code %0d)",
                                              final_code, want.last_code, want.code));
                codes_seen++;
            end
        end
        // long hold-off on request, else random idling
        if (hold_left > 0)
        begin
            out_ready <= 1'b0;
            hold_left--;
        end
        else if (stall_req)
        begin
            stall_req = 1'b0;
            hold_left = HOLD_CYCLES;
            out_ready <= 1'b0;
        end
        else
        begin
            out_ready <= ($urandom_range(99) >= recv_idle_pct);
        end
    end

    // Run watchdog
    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("TIMEOUT after %0d cycles, %0d codes still expected",
                     cycle_count, pending_codes.size());
            $display("lzw_byte_compressor: mismatch");
            $finish;
        end
    end

    initial
    begin : stimulus
        int i;
        clear_dictionary();

        // single-byte streams at both ends of the byte range
        add_row(8'h00, 1'b1, 1'b1, 1, {12'h000, 1'b1}, '0);
        add_row(8'hFF, 1'b1, 1'b1, 1, {12'h0FF, 1'b1}, '0);
        // two-byte stream, miss on the last byte gives two codes
        add_row(8'hFF, 1'b0, 1'b1, 0, '0, '0);
        add_row(8'h00, 1'b1, 1'b1, 2, {12'h0FF, 1'b0}, {12'h000, 1'b1});
        // run of one value: prefix grows through fresh entries from 256
        add_row(8'h41, 1'b0, 1'b1, 0, '0, '0);
        add_row(8'h41, 1'b0, 1'b1, 1, {12'h041, 1'b0}, '0);
        add_row(8'h41, 1'b0, 1'b1, 0, '0, '0);
        add_row(8'h41, 1'b0, 1'b1, 1, {12'd256, 1'b0}, '0);
        add_row(8'h41, 1'b0, 1'b1, 0, '0, '0);
        add_row(8'h41, 1'b1, 1'b1, 1, {12'd257, 1'b1}, '0);
        // repeated pair, stream ends on a hit
        add_row(8'h12, 1'b0, 1'b0, 0, '0, '0);
        add_row(8'h34, 1'b0, 1'b0, 0, '0, '0);
        add_row(8'h12, 1'b0, 1'b0, 0, '0, '0);
        add_row(8'h34, 1'b1, 1'b0, 0, '0, '0);
        // hit mid-stream, then miss on the last byte
        add_row(8'hA5, 1'b0, 1'b0, 0, '0, '0);
        add_row(8'h5A, 1'b0, 1'b0, 0, '0, '0);
        add_row(8'hA5, 1'b0, 1'b0, 0, '0, '0);
        add_row(8'h5A, 1'b0, 1'b0, 0, '0, '0);
        add_row(8'h00, 1'b1, 1'b0, 0, '0, '0);

        // reset
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed table, then random streams: sender idles less than receiver
        send_idle_pct = 33;
        recv_idle_pct = 87;
        for (i = 0; i < rows.size(); i++)
            send_byte(rows[i].b, rows[i].eos, rows[i].typed, rows[i].n, rows[i].r0, rows[i].r1);
        while (items_sent < 550)
            random_stream();

        // receiver idles less than sender
        send_idle_pct = 87;
        recv_idle_pct = 33;
        while (items_sent < 1080)
            random_stream();

        // no idling; long receiver hold-off while items keep coming
        send_idle_pct = 0;
        recv_idle_pct = 0;
        stall_req = 1'b1;
        while (items_sent < 1350)
            random_stream();

        // one long stream of random bytes grows a larger dictionary
        for (i = 0; i < LONG_STREAM; i++)
            send_byte(8'($urandom), i == LONG_STREAM - 1, 1'b0, 0, '0, '0);
        streams_sent++;
        if (LONG_STREAM > longest_stream)
            longest_stream = LONG_STREAM;

        while (items_sent < 1600)
            random_stream();

        // drain
        in_valid <= 1'b0;
        while (pending_codes.size() != 0)
            @(posedge clk);
        repeat (TAIL_CYCLES) @(posedge clk);
        if (pending_codes.size() != 0)
            report_mismatch($sformatf("%0d codes never arrived", pending_codes.size()));

        $display("Ran %0d byte items in %0d streams (longest %0d), %0d codes checked",
                 items_sent, streams_sent, longest_stream, codes_seen);
        $display("%0d misses with the dictionary full, %0d-cycle receiver hold-off, %0d errors",
                 full_misses, HOLD_CYCLES, errors);
        if (errors == 0)
            $display("lzw_byte_compressor: match");
        else
            $display("lzw_byte_compressor: mismatch");
        $finish;
    end

endmodule
